/* rtl/core/htfd_pkg.sv */
// Package: shared types and constants of the humidity/temperature frame decoder.
`default_nettype none

package htfd_pkg;

  // Position of a byte inside the six-byte sensor reply.
  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // Control handed from the frame tracker to the conversion unit.
  typedef struct packed {
    logic take;
    pos_t pos;
  } frame_ctrl_t;

  // CRC-8 parameters of the sensor.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Temperature scaling: floor(raw * 17500 / 65535) - 4500.
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [16:0] TEMP_DIV    = 17'd65535;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  // Humidity scaling: (raw * 625) >> 12.
  localparam logic [9:0] HUM_SCALE = 10'd625;
  localparam int         HUM_SHIFT = 12;

endpackage

`default_nettype wire

/* rtl/core/htfd_if.sv */
// Interfaces: input byte channel and result channel of the frame decoder.
`default_nettype none

interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic               temperature_crc_ok;
  logic               humidity_crc_ok;
  logic               frame_ok;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output temperature_crc_ok, output humidity_crc_ok, output frame_ok,
                  input ready);
  modport sink   (input valid, input temperature_centi, input humidity_centi,
                  input temperature_crc_ok, input humidity_crc_ok, input frame_ok,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/humidity_temp_frame_decoder_core.sv */
// Top level of the humidity/temperature frame decoder with its result register.
//
//   Channel | Direction | Word                                   | Per frame
//   in_ch   | sink      | rx_byte[7:0], frame_start              | 6 words
//   out_ch  | source    | temperature_centi, humidity_centi,     | 1 word
//           |           | temperature_crc_ok, humidity_crc_ok,   |
//           |           | frame_ok                               |
//
// One input word is taken per cycle while the output register has room; the
// result is registered in the cycle after the sixth word of a frame is taken.
// The temperature is scaled in two registered steps while the check byte and
// humidity MSB pass, so no step adds latency. Reset clears the byte position,
// CRC and result valid. A stalled result stays in the output register; a new
// word is still taken when that register is empty or read in the same cycle.
`default_nettype none

module humidity_temp_frame_decoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  htfd_in_if.sink   in_ch,
  htfd_out_if.source out_ch
);
  import htfd_pkg::*;

  frame_ctrl_t        ctrl;
  logic               take, load;
  logic [15:0]        temp_word, hum_word;
  logic               temp_ok, hum_ok;
  logic signed [14:0] temp_centi;
  logic        [13:0] hum_centi;

  logic               out_valid_r, out_valid_nxt;
  logic signed [14:0] out_temp_r;
  logic        [13:0] out_hum_r;
  logic               out_temp_ok_r, out_hum_ok_r;

  // Accept a word whenever the result register can make room.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .ctrl        (ctrl),
    .temp_word   (temp_word),
    .hum_word    (hum_word),
    .temp_ok     (temp_ok),
    .hum_ok      (hum_ok)
  );

  htfd_conv u_conv (
    .clk        (clk),
    .ctrl       (ctrl),
    .temp_word  (temp_word),
    .hum_word   (hum_word),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi)
  );

  // The humidity check byte closes a frame and loads the result.
  assign load          = ctrl.take && ctrl.pos == POS_H_CRC;
  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_temp_r    <= temp_centi;
      out_hum_r     <= hum_centi;
      out_temp_ok_r <= temp_ok;
      out_hum_ok_r  <= hum_ok;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.temperature_centi  = out_temp_r;
  assign out_ch.humidity_centi     = out_hum_r;
  assign out_ch.temperature_crc_ok = out_temp_ok_r;
  assign out_ch.humidity_crc_ok    = out_hum_ok_r;
  assign out_ch.frame_ok           = out_temp_ok_r && out_hum_ok_r;

endmodule

`default_nettype wire

/* rtl/core/htfd_crc8.sv */
// CRC-8 update of one byte, MSB first.
`default_nettype none

module htfd_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  output logic      [7:0] crc_out
);
  import htfd_pkg::*;

  // Eight shift steps of the polynomial division.
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

/* rtl/core/htfd_frame.sv */
// Frame tracker: byte position, running CRC, captured data words and check flags.
`default_nettype none

module htfd_frame (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 frame_start,
  output htfd_pkg::frame_ctrl_t     ctrl,
  output logic      [15:0]          temp_word,
  output logic      [15:0]          hum_word,
  output logic                      temp_ok,
  output logic                      hum_ok
);
  import htfd_pkg::*;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_cur, crc_fed;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_ok_r, temp_ok_nxt;
  logic        restart;

  // A start flag, or a position that cannot occur, opens a new frame.
  assign restart = frame_start ||
                   !(pos_r inside {POS_T_MSB, POS_T_LSB, POS_T_CRC,
                                   POS_H_MSB, POS_H_LSB, POS_H_CRC});
  assign pos_eff = restart ? POS_T_MSB : pos_r;
  assign crc_cur = restart ? CRC_INIT : crc_r;

  htfd_crc8 u_crc8 (
    .crc_in  (crc_cur),
    .data_in (rx_byte),
    .crc_out (crc_fed)
  );

  // Next byte position.
  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      case (pos_eff)
        POS_T_MSB: pos_nxt = POS_T_LSB;
        POS_T_LSB: pos_nxt = POS_T_CRC;
        POS_T_CRC: pos_nxt = POS_H_MSB;
        POS_H_MSB: pos_nxt = POS_H_LSB;
        POS_H_LSB: pos_nxt = POS_H_CRC;
        POS_H_CRC: pos_nxt = POS_T_MSB;
        default:   pos_nxt = POS_T_MSB;
      endcase
    end
  end

  // Word capture and CRC update for the byte at the current position.
  always_comb begin
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_ok_nxt   = temp_ok_r;
    if (take) begin
      case (pos_eff)
        POS_T_MSB: begin
          temp_word_nxt = {rx_byte, 8'h00};
          crc_nxt       = crc_fed;
        end
        POS_T_LSB: begin
          temp_word_nxt = {temp_word_r[15:8], rx_byte};
          crc_nxt       = crc_fed;
        end
        POS_T_CRC: begin
          temp_ok_nxt = (crc_cur == rx_byte);
          crc_nxt     = CRC_INIT;
        end
        POS_H_MSB: begin
          hum_word_nxt = {rx_byte, hum_word_r[7:0]};
          crc_nxt      = crc_fed;
        end
        POS_H_LSB: begin
          hum_word_nxt = {hum_word_r[15:8], rx_byte};
          crc_nxt      = crc_fed;
        end
        default: begin
          crc_nxt = CRC_INIT;
        end
      endcase
    end
  end

  // Control state is reset; the data words are always written before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_T_MSB;
      crc_r     <= CRC_INIT;
      temp_ok_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      temp_ok_r <= temp_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_word_r <= temp_word_nxt;
    hum_word_r  <= hum_word_nxt;
  end

  assign ctrl.take = take;
  assign ctrl.pos  = pos_eff;
  assign temp_word = temp_word_r;
  assign hum_word  = hum_word_r;
  assign temp_ok   = temp_ok_r;
  assign hum_ok    = (crc_cur == rx_byte);

endmodule

`default_nettype wire

/* rtl/core/htfd_conv.sv */
// Conversion unit: raw words to hundredths of a degree and of a percent.
`default_nettype none

module htfd_conv (
  input  wire logic                  clk,
  input  wire htfd_pkg::frame_ctrl_t ctrl,
  input  wire logic        [15:0]    temp_word,
  input  wire logic        [15:0]    hum_word,
  output logic signed      [14:0]    temp_centi,
  output logic             [13:0]    hum_centi
);
  import htfd_pkg::*;

  logic [30:0] prod_r, prod_nxt;
  logic [14:0] temp_r, temp_nxt;
  logic [14:0] quot_lo, quot;
  logic [16:0] rem_est;
  logic [25:0] hum_prod;

  // Temperature product, taken while the temperature check byte goes by.
  always_comb begin
    prod_nxt = prod_r;
    if (ctrl.take && ctrl.pos == POS_T_CRC) begin
      prod_nxt = 31'(temp_word) * 31'(TEMP_SCALE);
    end
  end

  // Division by 65535: the estimate prod>>16 is low by at most one.
  always_comb begin
    quot_lo = prod_r[30:16];
    rem_est = {1'b0, prod_r[15:0]} + 17'(quot_lo);
    quot    = quot_lo + 15'(rem_est >= TEMP_DIV);
    temp_nxt = temp_r;
    if (ctrl.take && ctrl.pos == POS_H_MSB) begin
      temp_nxt = quot - TEMP_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    temp_r <= temp_nxt;
  end

  // Humidity scaling straight from the captured word.
  assign hum_prod   = 26'(hum_word) * 26'(HUM_SCALE);
  assign hum_centi  = 14'(hum_prod >> HUM_SHIFT);
  assign temp_centi = signed'(temp_r);

endmodule

`default_nettype wire

/* rtl/core/htfd_checker.sv */
// Port-level checker for the frame decoder, bound to its top level.
`default_nettype none

module htfd_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_frame_start,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [14:0] out_temperature_centi,
  input wire logic        [13:0] out_humidity_centi,
  input wire logic               out_temperature_crc_ok,
  input wire logic               out_humidity_crc_ok,
  input wire logic               out_frame_ok
);

  // A result word is never shown in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its readings.
  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_temperature_centi) &&
                                $stable(out_humidity_centi))
    else $error("result changed while stalled");

  // The frame flag is the conjunction of both checks, and readings are in range.
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_ok == (out_temperature_crc_ok && out_humidity_crc_ok)) &&
                  (out_humidity_centi <= 14'd9999) &&
                  (out_temperature_centi >= -15'sd4500) &&
                  (out_temperature_centi <= 15'sd13000))
    else $error("inconsistent result word");

  // A frame's first byte never brings a new result.
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_start |=>
      !out_valid || ($past(out_valid) && !$past(out_ready)))
    else $error("result produced by a frame start byte");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_ch.valid),
  .in_ready               (in_ch.ready),
  .in_frame_start         (in_ch.frame_start),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .out_temperature_centi  (out_ch.temperature_centi),
  .out_humidity_centi     (out_ch.humidity_centi),
  .out_temperature_crc_ok (out_ch.temperature_crc_ok),
  .out_humidity_crc_ok    (out_ch.humidity_crc_ok),
  .out_frame_ok           (out_ch.frame_ok)
);

`default_nettype wire

/* tb/humidity_temp_frame_decoder_core_test.sv */
// Self-checking testbench of the humidity/temperature frame decoder, with its own decoder model.
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_core_test;
  import htfd_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last expected result has arrived.
  localparam int DRAIN_CYCLES = 4;
  // Least number of random words sent in each random phase.
  localparam int WORDS_PER_PHASE = 225;

  // One decoded reading, laid out as the result channel carries it.
  typedef struct packed {
    logic [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic        temperature_crc_ok;
    logic        humidity_crc_ok;
    logic        frame_ok;
  } reading_t;

  // One row of the directed stimulus; want is used only where known_result is set.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       known_result;
    reading_t   want;
  } directed_row_t;

  // Directed frames: all-zero and all-ones words with good check bytes, a frame that
  // follows another without frame_start, a resync in mid frame followed by a bad
  // temperature check byte, and a frame whose humidity check byte is wrong.
  localparam directed_row_t DIRECTED[26] = '{
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h81, 1'b0, 1'b1, '{15'(-4500), 14'd0, 1'b1, 1'b1, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b1, '{15'(13000), 14'd9999, 1'b1, 1'b1, 1'b1}},
    '{8'h12, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b0, 1'b1, '{15'(-4500), 14'd9999, 1'b0, 1'b1, 1'b0}},
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h92, 1'b0, 1'b0, '0},
    '{8'hBE, 1'b0, 1'b0, '0},
    '{8'hEF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  htfd_in_if  in_ch();
  htfd_out_if out_ch();

  humidity_temp_frame_decoder_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder model state.
  pos_t        frame_pos;
  logic [7:0]  word_crc;
  logic [15:0] temp_raw;
  logic        temp_pass;
  logic [7:0]  hum_msb;
  logic [7:0]  hum_lsb;

  reading_t pending_readings[$];
  int       mismatch_count;
  int       sender_idle_pct;
  int       sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Feeds one byte into a CRC-8, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] crc8_word(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Mostly random words, with the two extremes mixed in.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Advances the decoder model by one received byte; returns 1 when a reading is due.
  function automatic logic decode_sensor_byte(input logic [7:0] b, input logic fs,
                                              output reading_t r);
    logic [31:0] scaled;
    logic [31:0] hum_raw;
    logic        hum_pass;
    logic        got;
    got = 1'b0;
    r = '0;
    // A frame_start drops any partial frame.
    if (fs) begin
      frame_pos = POS_T_MSB;
      word_crc = CRC_INIT;
    end
    case (frame_pos)
      POS_T_MSB: begin
        temp_raw = {b, 8'h00};
        word_crc = crc8_step(word_crc, b);
      end
      POS_T_LSB: begin
        temp_raw[7:0] = b;
        word_crc = crc8_step(word_crc, b);
      end
      POS_T_CRC: begin
        temp_pass = (word_crc == b);
        word_crc = CRC_INIT;
      end
      POS_H_MSB: begin
        hum_msb = b;
        word_crc = crc8_step(word_crc, b);
      end
      POS_H_LSB: begin
        hum_lsb = b;
        word_crc = crc8_step(word_crc, b);
      end
      default: begin
        // Readings are produced even when a check byte is wrong.
        scaled = ({16'd0, temp_raw} * 32'd17500) / 32'd65535;
        hum_raw = {16'd0, hum_msb, hum_lsb};
        hum_pass = (word_crc == b);
        r.temperature_centi = 15'(scaled - 32'd4500);
        r.humidity_centi = 14'((32'd625 * hum_raw) >> 12);
        r.temperature_crc_ok = temp_pass;
        r.humidity_crc_ok = hum_pass;
        r.frame_ok = temp_pass & hum_pass;
        word_crc = CRC_INIT;
        got = 1'b1;
      end
    endcase
    frame_pos = (frame_pos == POS_H_CRC) ? POS_T_MSB : pos_t'(frame_pos + 3'd1);
    return got;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Sends one input word, with random idle cycles ahead of it, and records what it
  // should produce once the block has accepted it.
  task automatic push_byte(input logic [7:0] b, input logic fs, input logic known,
                           input reading_t want);
    reading_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (decode_sensor_byte(b, fs, r)) pending_readings.push_back(known ? want : r);
  endtask

  // The result side stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Each accepted result word is checked against the oldest expected reading.
  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result word with no reading expected");
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.temperature_centi !== want.temperature_centi)
          flag_mismatch($sformatf("temperature_centi got %0d want %0d",
                        $signed(out_ch.temperature_centi), $signed(want.temperature_centi)));
        if (out_ch.humidity_centi !== want.humidity_centi)
          flag_mismatch($sformatf("humidity_centi got %0d want %0d",
                        out_ch.humidity_centi, want.humidity_centi));
        if (out_ch.temperature_crc_ok !== want.temperature_crc_ok)
          flag_mismatch($sformatf("temperature_crc_ok got %b want %b",
                        out_ch.temperature_crc_ok, want.temperature_crc_ok));
        if (out_ch.humidity_crc_ok !== want.humidity_crc_ok)
          flag_mismatch($sformatf("humidity_crc_ok got %b want %b",
                        out_ch.humidity_crc_ok, want.humidity_crc_ok));
        if (out_ch.frame_ok !== want.frame_ok)
          flag_mismatch($sformatf("frame_ok got %b want %b", out_ch.frame_ok, want.frame_ok));
      end
    end
  end

  // Ends a hung run: too many cycles in a row with no word accepted on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] t_word;
    logic [15:0] h_word;
    logic [7:0]  frame_bytes[6];
    logic        first_fs;
    logic        resync;
    int          n;
    int          sent;

    mismatch_count = 0;
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.frame_start <= 1'b0;
    frame_pos = POS_T_MSB;
    word_crc = CRC_INIT;
    temp_raw = '0;
    temp_pass = 1'b0;
    hum_msb = '0;
    hum_lsb = '0;
    resync = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames, sent back to back.
    foreach (DIRECTED[i]) begin
      push_byte(DIRECTED[i].rx_byte, DIRECTED[i].frame_start, DIRECTED[i].known_result,
                DIRECTED[i].want);
    end

    // Random frames: no idling, idle sender, stalling receiver, then both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 69; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 69; end
        default: begin sender_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        if ($urandom_range(99) < 12) begin
          // Noise: a short run of random bytes, sometimes with a stray frame_start.
          n = $urandom_range(5, 1);
          for (int k = 0; k < n; k++) begin
            push_byte(8'($urandom), ($urandom_range(7) == 0), 1'b0, '0);
          end
          sent += n;
          resync = 1'b1;
        end else begin
          // Well-formed frame with random words; check bytes are mostly right.
          t_word = pick_word();
          h_word = pick_word();
          frame_bytes[0] = t_word[15:8];
          frame_bytes[1] = t_word[7:0];
          frame_bytes[2] = ($urandom_range(99) < 85) ? crc8_word(t_word) : 8'($urandom);
          frame_bytes[3] = h_word[15:8];
          frame_bytes[4] = h_word[7:0];
          frame_bytes[5] = ($urandom_range(99) < 85) ? crc8_word(h_word) : 8'($urandom);
          first_fs = resync ? ($urandom_range(4) != 0) : 1'($urandom_range(1));
          for (int k = 0; k < 6; k++) begin
            push_byte(frame_bytes[k], (k == 0) ? first_fs : 1'b0, 1'b0, '0);
          end
          sent += 6;
          resync = 1'b0;
        end
      end
    end

    // Drain: wait for every expected reading, then wait out DRAIN_CYCLES.
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_readings.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
